@@ src/sqwo_pkg.sv @@
// ----------------------------------------------------------------------------
// sqwo_pkg
// Shared constants and functions for the shaped quarter-wave oscillator.
// ----------------------------------------------------------------------------
package sqwo_pkg;

    localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] REG_AMP_MAX     = 2'd1;
    localparam logic [1:0] REG_AMP_MIN     = 2'd2;

    // floor square root, one result bit per pass
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res, rem, bitv;
        begin
            res  = '0;
            rem  = v;
            bitv = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    // r_j = sqrt(r_{j-1}) from 0.5, Q2.30, j = 1..16 packed low to high
    function automatic logic [511:0] root_chain();
        logic [511:0] t;
        logic [63:0]  r;
        begin
            t = '0;
            r = 64'd1 << 29;
            for (int j = 0; j < 16; j++) begin
                r = isqrt64(r << 30);
                t[j*32 +: 32] = r[31:0];
            end
            return t;
        end
    endfunction

    localparam logic [511:0] ROOT_TABLE = root_chain();

    // exp2 root chain entry, index 0 holds r_1
    function automatic logic [31:0] root_q30(input logic [3:0] j);
        begin
            return ROOT_TABLE[32*j +: 32];
        end
    endfunction

endpackage

@@ src/sqwo_divider.sv @@
// ----------------------------------------------------------------------------
// sqwo_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sqwo_divider import sqwo_pkg::*; #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quo
);
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS+1:0] w_try;
    logic [DEN_BITS:0]   w_sh;

    assign w_sh  = {r_rem[DEN_BITS-1:0], r_quo[NUM_BITS-1]};
    assign w_try = {1'b0, w_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CW'(NUM_BITS);
            end else if (r_busy) begin
                if (!w_try[DEN_BITS+1]) begin
                    r_rem <= w_try[DEN_BITS:0];
                    r_quo <= {r_quo[NUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[NUM_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ src/shaped_quarter_wave_oscillator.sv @@
// An accepted word runs two 48-step divisions plus capture, 16 log2 squarings
// and 16 exp2 steps; when freq_q8 is 0 the divisions are skipped.
// A new word is taken only once the last is done, as all steps use the shared
// divider and 32 x 32 multiplier; a held output word only delays the last step.
// Reset (synchronous, active low): position 0, quadrant 0, registers to
// sample_rate 48000, amp_max 32767, amp_min -32767.
// ----------------------------------------------------------------------------
// shaped_quarter_wave_oscillator
// Sequencer around one divider and one multiplier that forms x^s ramps.
// ----------------------------------------------------------------------------
module shaped_quarter_wave_oscillator import sqwo_pkg::*; #(
    parameter int SAMPLE_BITS    = 16,
    parameter int RAMP_FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [23:0]            i_freq_q8,
    input  logic [15:0]            i_shape_q12,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SAMPLE_BITS-1:0] o_sample_out,
    output logic [1:0]             o_quadrant_out,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    localparam int RF  = RAMP_FRAC_BITS;
    localparam int NB  = 32 + RF;          // dividend width
    localparam int PW  = $clog2(RF + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_QDIV, S_XSTART, S_XDIV, S_BASE, S_NORM, S_LOG,
        S_MULE, S_EXP, S_AMP, S_OUT
    } t_state;

    t_state r_state;
    logic [17:0]            r_sample_rate;
    logic [SAMPLE_BITS-2:0] r_amp_max;
    logic [SAMPLE_BITS-1:0] r_amp_min;
    logic [31:0]            r_pos;
    logic [1:0]             r_quad;
    logic [23:0]            r_freq;
    logic [15:0]            r_shape;
    logic [31:0]            r_quarter;
    logic [RF:0]            r_base;
    logic [PW-1:0]          r_p;
    logic [31:0]            r_m;       // Q2.30 mantissa / exp accumulator
    logic [15:0]            r_frac;
    logic [4:0]             r_step;
    logic [39:0]            r_e;
    logic [16:0]            r_pw;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_ovalid;

    // divider
    logic          w_dstart, w_ddone;
    logic [NB-1:0] w_dnum, w_dquo;
    logic [31:0]   w_dden;

    sqwo_divider #(.NUM_BITS(NB), .DEN_BITS(32)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quo(w_dquo)
    );

    assign w_dstart = (r_state == S_IDLE && i_valid && !o_stall
                       && i_freq_q8 != 24'd0) || (r_state == S_XSTART);
    assign w_dnum = (r_state == S_IDLE) ? NB'({r_sample_rate, 14'd0})
                                        : {r_pos, RF'(0)};
    assign w_dden = (r_state == S_IDLE) ? {8'd0, i_freq_q8} : r_quarter;

    // shared multiplier, 32 x 32
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mp;
    always_comb begin
        w_ma = r_m;
        w_mb = r_m;
        case (r_state)
            S_MULE: begin w_ma = {16'd0, r_shape}; w_mb = r_e[31:0]; end
            S_EXP:  w_mb = root_q30(r_step[3:0]);
            // bit 31 of r_m carries the sign of the amplitude here
            S_OUT:  begin w_ma = {15'd0, r_pw}; w_mb = {1'b0, r_m[30:0]}; end
            default: ;
        endcase
    end
    assign w_mp = w_ma * w_mb;

    logic [63:0] w_sq;
    assign w_sq = w_mp >> 30;

    // top set bit of the ramp base
    logic [PW-1:0] w_top;
    always_comb begin
        w_top = '0;
        for (int i = 0; i <= RF; i++)
            if (r_base[i]) w_top = PW'(i);
    end

    logic [SAMPLE_BITS-1:0]         w_amp;
    logic signed [SAMPLE_BITS+18:0] w_prod;
    logic signed [SAMPLE_BITS+18:0] w_sv;
    localparam logic signed [SAMPLE_BITS+18:0] SMAX = (1 <<< (SAMPLE_BITS-1)) - 1;
    // |amp| of the current quadrant
    assign w_amp  = r_quad[1] ? (r_amp_min[SAMPLE_BITS-1] ? -r_amp_min : r_amp_min)
                              : {1'b0, r_amp_max};
    // magnitude is truncated first, so the signed result rounds toward zero
    assign w_prod = $signed({19'd0, w_mp[SAMPLE_BITS+15:16]});
    assign w_sv   = r_m[31] ? -w_prod : w_prod;

    logic [32:0] w_np;
    logic [RF:0] w_x;
    assign w_np = ({1'b0, r_pos} + 33'd256 > 33'hFFFF_FFFF) ? 33'hFFFF_FFFF
                                                          : {1'b0, r_pos} + 33'd256;
    assign w_x = (w_dquo > NB'((1 << RF) - 1)) ? (RF+1)'((1 << RF) - 1)
                                               : (RF+1)'(w_dquo);

    // last step may load the output word once the previous one leaves
    logic w_out_go;
    assign w_out_go = !r_ovalid || !i_stall;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ovalid      <= 1'b0;
            r_pos         <= '0;
            r_quad        <= '0;
            r_sample_rate <= 18'd48000;
            r_amp_max     <= '1;
            r_amp_min     <= SAMPLE_BITS'((1 << (SAMPLE_BITS-1)) + 1);
        end else begin
            if (r_state == S_OUT && w_out_go) r_ovalid <= 1'b1;
            else if (o_valid && !i_stall)     r_ovalid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[17:0];
                    REG_AMP_MAX:     r_amp_max     <= i_cfg_data[SAMPLE_BITS-2:0];
                    REG_AMP_MIN:     r_amp_min     <= i_cfg_data[SAMPLE_BITS-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (i_valid && !o_stall) begin
                    r_freq  <= i_freq_q8;
                    r_shape <= i_shape_q12;
                    if (i_freq_q8 == 24'd0) begin
                        r_base  <= r_quad[0] ? (RF+1)'(1 << RF) : '0;
                        r_state <= S_NORM;
                    end else r_state <= S_QDIV;
                end
                S_QDIV: if (w_ddone) begin
                    r_quarter <= (w_dquo == '0) ? 32'd1 : w_dquo[31:0];
                    r_state   <= S_XSTART;
                end
                S_XSTART: r_state <= S_XDIV;
                S_XDIV: if (w_ddone) begin
                    r_base  <= r_quad[0] ? (RF+1)'(1 << RF) - w_x : w_x;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // top-bit search is a small priority encode over RF+1 bits
                    r_p     <= w_top;
                    r_state <= S_BASE;
                    r_frac  <= '0;
                    r_step  <= 5'd15;
                end
                S_BASE: begin
                    r_m     <= 32'(({31'd0, r_base} << (30 - r_p)));
                    r_state <= S_LOG;
                end
                S_LOG: begin
                    if (w_sq >= 64'h8000_0000) begin
                        r_m <= w_sq[32:1];
                        r_frac[r_step[3:0]] <= 1'b1;
                    end else r_m <= w_sq[31:0];
                    if (r_step == 5'd0) begin
                        r_e     <= 40'(((RF - r_p) << 16)) - {24'd0, r_frac}
                                   - ((w_sq >= 64'h8000_0000) ? 40'd1 : 40'd0);
                        r_state <= S_MULE;
                    end else r_step <= r_step - 1'b1;
                end
                S_MULE: begin
                    r_e     <= 40'(w_mp >> 12);
                    r_m     <= 32'h4000_0000;
                    r_step  <= 5'd0;
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    if (r_e[15 - r_step[3:0]]) r_m <= w_sq[31:0];
                    if (r_step == 5'd15) r_state <= S_AMP;
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd15) begin
                        if (r_base == '0) r_pw <= (r_shape == 16'd0) ? 17'h10000 : 17'd0;
                        else if (r_e[39:16] >= 24'd32) r_pw <= 17'd0;
                        else r_pw <= 17'(({r_e[15 - r_step[3:0]] ? w_sq[31:0] : r_m})
                                         >> (14 + r_e[20:16]));
                    end
                end
                S_AMP: begin
                    // |amp| below, its sign in bit 31
                    r_m     <= {r_quad[1] & r_amp_min[SAMPLE_BITS-1],
                                {(31-SAMPLE_BITS){1'b0}}, w_amp};
                    r_state <= S_OUT;
                end
                S_OUT: if (w_out_go) begin
                    r_sample <= (w_sv > SMAX) ? SAMPLE_BITS'(SMAX)
                              : (w_sv < -SMAX - 1) ? SAMPLE_BITS'(-SMAX - 1)
                              : SAMPLE_BITS'(w_sv);
                    o_quadrant_out <= r_quad;
                    if (r_freq != 24'd0) begin
                        if (w_np >= {1'b0, r_quarter}) begin
                            r_pos  <= 32'(w_np - {1'b0, r_quarter});
                            r_quad <= r_quad + 1'b1;
                        end else r_pos <= w_np[31:0];
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_sample_out = r_sample;

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_sample_out))
        else $error("output dropped");
    a_quad_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_OUT) |=> $stable(r_quad)) else $error("quadrant moved");
endmodule

@@ test/sqwo_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sqwo_checker
// Watches the sample, result and register channels of the oscillator, keeps
// its own copy of position, quadrant and registers, and checks every result.
// ----------------------------------------------------------------------------
module sqwo_checker import sqwo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [23:0] i_freq_q8,
    input  logic [15:0] i_shape_q12,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_sample_out,
    input  logic [1:0]  i_quadrant_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [15:0] sample;
        logic [1:0]  quadrant;
    } t_wave_word;

    t_wave_word  wave_q[$];
    logic [17:0] rate_reg;
    logic [14:0] amp_hi_reg;
    logic [15:0] amp_lo_reg;
    logic [31:0] pos_q8;
    logic [1:0]  quad;
    logic [63:0] roots[1:16];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    initial begin
        logic [63:0] r;
        r = 64'd1 << 29;
        for (int j = 1; j <= 16; j++) begin
            r = int_sqrt(r << 30);
            roots[j] = r;
        end
    end

    // -log2(base / 2^16) in Q.16
    function automatic logic [63:0] neg_log2_q16(input logic [63:0] base);
        int          p;
        logic [63:0] m, frac;
        p    = 0;
        frac = 0;
        while (p < 40 && (base >> (p + 1)) != 0) p++;
        m = base << (30 - p);
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                frac[i] = 1'b1;
                m = m >> 1;
            end
        end
        return ((64'(16 - p)) << 16) - frac;
    endfunction

    // 2^(-e/65536) in Q.16
    function automatic logic [63:0] exp2_neg_q16(input logic [63:0] e);
        logic [63:0] acc, k;
        k   = e >> 16;
        acc = 64'd1 << 30;
        for (int j = 1; j <= 16; j++)
            if (e[16-j]) acc = (acc * roots[j]) >> 30;
        if (k >= 32) return 0;
        return acc >> (14 + k);
    endfunction

    function automatic t_wave_word next_wave(input logic [23:0] freq,
                                             input logic [15:0] shape);
        logic [63:0] quarter, x, base, pw, np;
        longint      amp, s;
        t_wave_word  w;
        quarter = 0;
        x       = 0;
        if (freq != 0) begin
            quarter = (64'(rate_reg) << 14) / freq;
            if (quarter == 0) quarter = 1;
            x = (64'(pos_q8) << 16) / quarter;
            if (x > 65535) x = 65535;
        end
        base = quad[0] ? 64'd65536 - x : x;
        if (base == 0) pw = (shape == 0) ? 64'd65536 : 64'd0;
        else           pw = exp2_neg_q16((64'(shape) * neg_log2_q16(base)) >> 12);
        amp = (quad < 2) ? longint'(amp_hi_reg) : longint'($signed(amp_lo_reg));
        s = (amp * longint'(pw)) / 65536;
        if (s > 32767)  s = 32767;
        if (s < -32768) s = -32768;
        w.sample   = s[15:0];
        w.quadrant = quad;
        // advance the phase accumulator
        if (freq != 0) begin
            np = 64'(pos_q8) + 256;
            if (np > 64'hFFFF_FFFF) np = 64'hFFFF_FFFF;
            if (np >= quarter) begin
                np   = np - quarter;
                quad = quad + 2'd1;
            end
            pos_q8 = np[31:0];
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_wave_word want;
        if (!i_rst_n) begin
            rate_reg   = 18'd48000;
            amp_hi_reg = 15'd32767;
            amp_lo_reg = -16'sd32767;
            pos_q8     = 0;
            quad       = 0;
            wave_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SAMPLE_RATE: rate_reg   = i_cfg_data[17:0];
                    REG_AMP_MAX:     amp_hi_reg = i_cfg_data[14:0];
                    REG_AMP_MIN:     amp_lo_reg = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                wave_q.push_back(next_wave(i_freq_q8, i_shape_q12));
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (wave_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected word: sample %0d quadrant %0d",
                                 $signed(i_sample_out), i_quadrant_out);
                end else begin
                    want = wave_q.pop_front();
                    if (want.sample !== i_sample_out || want.quadrant !== i_quadrant_out) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: sample exp %0d got %0d, quadrant exp %0d got %0d",
                                     $signed(want.sample), $signed(i_sample_out),
                                     want.quadrant, i_quadrant_out);
                    end
                end
            end
        end
        o_pending = wave_q.size();
    end

endmodule

@@ test/shaped_quarter_wave_oscillator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shaped_quarter_wave_oscillator_tb
// Drives sample requests and register writes into the oscillator under
// several register settings and handshake pressures; the checker predicts.
// ----------------------------------------------------------------------------
module shaped_quarter_wave_oscillator_tb import sqwo_pkg::*; ();

    localparam int IDLE_NONE = 0, IDLE_SEND = 1, IDLE_RECV = 2, IDLE_BOTH = 3;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int HOLD_LEN = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [23:0] i_freq_q8 = '0;
    logic [15:0] i_shape_q12 = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_sample_out;
    logic [1:0]  o_quadrant_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    int          fail_count, pending, checked;
    int          idle_mode = IDLE_NONE;
    int          hold_req = 0;       // bumped to ask for a long hold-off
    int          hold_seen = 0;
    int          hold_cycles = 0;
    int          sent = 0;
    logic [17:0] cur_rate = 18'd48000;

    always #5 i_clk = ~i_clk;

    shaped_quarter_wave_oscillator DUT (.*);

    sqwo_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_freq_q8, .i_shape_q12,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_sample_out(o_sample_out), .i_quadrant_out(o_quadrant_out),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // receiver: random stalls per mode, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_cycles <= HOLD_LEN;
            i_stall     <= 1'b1;
        end else if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= (idle_mode == IDLE_RECV) ? ($urandom_range(99) < 49) :
                       (idle_mode == IDLE_BOTH) ? ($urandom_range(99) < 7) : 1'b0;
        end
    end

    function automatic bit sender_idles();
        return (idle_mode == IDLE_SEND) ? ($urandom_range(99) < 49) :
               (idle_mode == IDLE_BOTH) ? ($urandom_range(99) < 7) : 1'b0;
    endfunction

    // one request word; valid stays high into the next word unless the sender idles
    task automatic send_word(input logic [23:0] freq, input logic [15:0] shape);
        while (sender_idles()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_freq_q8   <= freq;
        i_shape_q12 <= shape;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_SAMPLE_RATE) cur_rate = data[17:0];
    endtask

    // frequency for a quarter of 1 to 41 samples at this rate, or 0, or random
    function automatic logic [23:0] pick_freq();
        int          sel;
        logic [63:0] q, f;
        sel = $urandom_range(99);
        if (sel < 8)  return 24'd0;
        if (sel < 25) return 24'($urandom);
        q = 64'($urandom_range(1, 40)) * 256 + $urandom_range(255);
        f = (64'(cur_rate) << 14) / q;
        if (f > 64'hFF_FFFF) f = 64'hFF_FFFF;
        if (f == 0) f = 1;
        return f[23:0];
    endfunction

    function automatic logic [15:0] pick_shape();
        case ($urandom_range(4))
            0: return 16'd0;
            1: return 16'd4096;            // linear ramp
            2: return 16'($urandom_range(12288));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int n, input int mode);
        idle_mode = mode;
        repeat (n) send_word(pick_freq(), pick_shape());
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: frozen phase, extreme fields, shape 0 and 1, wraps
        send_word(24'd0, 16'd0);
        send_word(24'd0, 16'hFFFF);
        send_word(24'hFF_FFFF, 16'd0);
        send_word(24'hFF_FFFF, 16'hFFFF);
        repeat (6) send_word(24'd614400, 16'd4096);   // quarter of 5 samples
        repeat (6) send_word(24'd614400, 16'd8192);
        repeat (4) send_word(24'd3072000, 16'hFFFF);  // quarter of one sample
        send_word(24'd1, 16'd4096);                   // clipped ramp after slow freq
        send_word(24'd1536000, 16'd2048);
        drain();

        random_phase(280, IDLE_NONE);

        // pressure: receiver holds off while the sender keeps offering
        hold_req <= hold_req + 1;
        @(posedge i_clk);
        random_phase(40, IDLE_NONE);

        write_reg(REG_SAMPLE_RATE, 32'hFFFC_FFFF);    // upper bits dropped -> 65535
        write_reg(REG_AMP_MAX, 32'h0000_7FFF);
        write_reg(REG_AMP_MIN, 32'hFFFF_8000);        // -32768
        random_phase(280, IDLE_SEND);

        write_reg(REG_SAMPLE_RATE, 32'd1);
        write_reg(REG_AMP_MAX, 32'd0);
        write_reg(REG_AMP_MIN, 32'd0);
        random_phase(250, IDLE_RECV);

        write_reg(REG_SAMPLE_RATE, 32'd0);            // zero quarter forced to one
        write_reg(REG_AMP_MAX, 32'h0001_5555);
        write_reg(REG_AMP_MIN, 32'h0000_1234);        // positive low peak
        random_phase(100, IDLE_BOTH);

        write_reg(REG_UNMAPPED, $urandom);            // unmapped index, ignored
        write_reg(REG_SAMPLE_RATE, 32'd44100);
        write_reg(REG_AMP_MAX, $urandom);
        write_reg(REG_AMP_MIN, $urandom);
        random_phase(300, IDLE_BOTH);

        write_reg(REG_SAMPLE_RATE, {14'h2AAA, 18'h2AAAA});
        write_reg(REG_AMP_MAX, 32'h2AAA);
        write_reg(REG_AMP_MIN, 32'hD555);
        random_phase(200, IDLE_RECV);
        random_phase(200, IDLE_SEND);

        $display("covered %0d requests, %0d results checked, six register settings,",
                 sent, checked);
        $display("frozen phase, one-sample quarters, long output hold-off and idle mixes");
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #30ms;
        $display("timeout with %0d results outstanding", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
src/sqwo_pkg.sv
src/sqwo_divider.sv
src/shaped_quarter_wave_oscillator.sv
test/sqwo_checker.sv
test/shaped_quarter_wave_oscillator_tb.sv
